FILE: rtl/mi3_pkg.sv
package mi3_pkg;

  localparam int NENT  = 9;
  localparam int NPROD = 18;

  // operand pairs of the cofactor products; adjugate entry i = prod[2i] - prod[2i+1]
  localparam int PROD_A [NPROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int PROD_B [NPROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

FILE: rtl/mi3_in_if.sv
interface mi3_in_if #(parameter int ENTRY_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [ENTRY_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

FILE: rtl/mi3_out_if.sv
interface mi3_out_if #(parameter int ENTRY_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [ENTRY_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic singular;
  logic overflow;

  modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, overflow,
                 input ready);
  modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, overflow,
               output ready);
endinterface

FILE: rtl/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by the adjugate. A new matrix beat is taken every cycle
// unless the pipeline holds. The stages are one for the cofactor products, four for the
// adjugate and determinant, two for magnitudes and the divider setup, ENTRY_WIDTH + 1
// stages of nine parallel restoring dividers (the first tests for overflow and each later
// one gives one quotient bit), and the rounding, saturation and output register.
// Entries are rounded to nearest, halves away from zero; a zero determinant gives all-zero
// entries with singular set. The whole pipeline holds while a result waits to be taken.
module matrix_inverse_3x3 #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic        clk,
  input logic        rst,
  mi3_in_if.sink     req,
  mi3_out_if.source  rsp
);

  localparam int W    = ENTRY_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int AW   = 2 * W + 1;
  localparam int DETW = 3 * W + 3;
  localparam int RW   = 4 * W + 2 * F + 4;
  localparam int NDIV = W + 1;
  localparam int NST  = 7 + NDIV + 1;
  localparam int N    = mi3_pkg::NENT;

  logic [NST-1:0] vld;
  logic           en;

  assign en        = !vld[NST-1] || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  logic signed [W-1:0] m_in [N];
  assign m_in[0] = req.m00;
  assign m_in[1] = req.m01;
  assign m_in[2] = req.m02;
  assign m_in[3] = req.m10;
  assign m_in[4] = req.m11;
  assign m_in[5] = req.m12;
  assign m_in[6] = req.m20;
  assign m_in[7] = req.m21;
  assign m_in[8] = req.m22;

  logic signed [2*W-1:0]  prod [mi3_pkg::NPROD];
  logic signed [W-1:0]    row1 [3];
  logic signed [W-1:0]    row2 [3];
  logic signed [AW-1:0]   adj2 [N];
  logic signed [AW-1:0]   adj3 [N];
  logic signed [AW-1:0]   adj4 [N];
  logic signed [AW-1:0]   adj5 [N];
  logic signed [2*W+1:0]  plo [3];
  logic signed [2*W+1:0]  phi [3];
  logic signed [DETW-1:0] term [3];
  logic signed [DETW-1:0] det5;
  logic [AW-1:0]          cabs6 [N];
  logic [DETW-1:0]        dabs6;
  logic [N-1:0]           neg6;
  logic                   zero6;

  logic [RW-1:0] rem_d [NDIV+1][N];
  logic [W-1:0]  q_d   [NDIV+1][N];
  logic [N-1:0]  sat_d [NDIV+1];
  logic [N-1:0]  neg_d [NDIV+1];
  logic          zero_d [NDIV+1];
  logic [RW-1:0] den_d [NDIV+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::NPROD; i++) begin
        prod[i] <= (2*W)'(m_in[mi3_pkg::PROD_A[i]]) * (2*W)'(m_in[mi3_pkg::PROD_B[i]]);
      end
      for (int j = 0; j < 3; j++) begin
        row1[j] <= m_in[j];
        row2[j] <= row1[j];
        plo[j]  <= (2*W+2)'(row2[j]) * (2*W+2)'($signed({1'b0, adj2[3*j][W-1:0]}));
        phi[j]  <= (2*W+2)'(row2[j]) * (2*W+2)'($signed(adj2[3*j][AW-1:W]));
        term[j] <= (DETW'(phi[j]) <<< W) + DETW'(plo[j]);
      end
      for (int i = 0; i < N; i++) begin
        adj2[i]  <= AW'(prod[2*i]) - AW'(prod[2*i+1]);
        adj3[i]  <= adj2[i];
        adj4[i]  <= adj3[i];
        adj5[i]  <= adj4[i];
        cabs6[i] <= adj5[i][AW-1] ? AW'(-adj5[i]) : AW'(adj5[i]);
        neg6[i]  <= adj5[i][AW-1] ^ det5[DETW-1];
        rem_d[0][i] <= (RW'(cabs6[i]) << (2*F+1)) + RW'(dabs6);
        q_d[0][i]   <= '0;
      end
      det5      <= term[0] + term[1] + term[2];
      dabs6     <= det5[DETW-1] ? DETW'(-det5) : DETW'(det5);
      zero6     <= (det5 == '0);
      den_d[0]  <= RW'(dabs6) << 1;
      neg_d[0]  <= neg6;
      zero_d[0] <= zero6;
      sat_d[0]  <= '0;
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int K = W - j;
    logic [RW-1:0] sub;
    assign sub = den_d[j] << K;

    always_ff @(posedge clk) begin
      if (en) begin
        den_d[j+1]  <= den_d[j];
        neg_d[j+1]  <= neg_d[j];
        zero_d[j+1] <= zero_d[j];
        for (int i = 0; i < N; i++) begin
          if (j == 0) begin
            sat_d[j+1][i] <= (rem_d[j][i] >= sub);
            rem_d[j+1][i] <= rem_d[j][i];
            q_d[j+1][i]   <= q_d[j][i];
          end else begin
            sat_d[j+1][i] <= sat_d[j][i];
            if (rem_d[j][i] >= sub) begin
              rem_d[j+1][i] <= rem_d[j][i] - sub;
              q_d[j+1][i]   <= q_d[j][i] | (W'(1) << (K % W));
            end else begin
              rem_d[j+1][i] <= rem_d[j][i];
              q_d[j+1][i]   <= q_d[j][i];
            end
          end
        end
      end
    end
  end

  logic [W-1:0] lim [N];
  logic [W-1:0] mag [N];
  logic [N-1:0] over;
  logic [W-1:0] r_next [N];
  logic [W-1:0] r_out [N];
  logic         singular;
  logic         overflow;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lim[i]  = neg_d[NDIV][i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      over[i] = sat_d[NDIV][i] || (q_d[NDIV][i] > lim[i]);
      mag[i]  = over[i] ? lim[i] : q_d[NDIV][i];
      if (zero_d[NDIV]) begin
        r_next[i] = '0;
      end else begin
        r_next[i] = neg_d[NDIV][i] ? W'(-mag[i]) : mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out    <= r_next;
      singular <= zero_d[NDIV];
      overflow <= !zero_d[NDIV] && (|over);
    end
  end

  assign rsp.r00      = r_out[0];
  assign rsp.r01      = r_out[1];
  assign rsp.r02      = r_out[2];
  assign rsp.r10      = r_out[3];
  assign rsp.r11      = r_out[4];
  assign rsp.r12      = r_out[5];
  assign rsp.r20      = r_out[6];
  assign rsp.r21      = r_out[7];
  assign rsp.r22      = r_out[8];
  assign rsp.singular = singular;
  assign rsp.overflow = overflow;

endmodule

FILE: test/tb_matrix_inverse_3x3.sv
`timescale 1ns / 100ps

module tb_matrix_inverse_3x3;

  localparam int W = 32;
  localparam int F = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [W-1:0] entry_t;
  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    entry_t [mi3_pkg::NENT-1:0] r;
    logic singular;
    logic overflow;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mi3_in_if  #(.ENTRY_WIDTH(W)) req();
  mi3_out_if #(.ENTRY_WIDTH(W)) rsp();

  matrix_inverse_3x3 #(.ENTRY_WIDTH(W), .FRAC_BITS(F)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  inverse_t expected_q[$];
  int errors = 0;
  int idle_pct = 38;
  int idle_cycles = 0;

  function automatic inverse_t invert_matrix(entry_t m[mi3_pkg::NENT]);
    inverse_t res;
    wide_t a[mi3_pkg::NENT];
    wide_t adj[mi3_pkg::NENT];
    wide_t det, num, den, q, lim;
    logic neg;
    res = '0;
    for (int i = 0; i < mi3_pkg::NENT; i++) a[i] = m[i];
    for (int i = 0; i < mi3_pkg::NENT; i++)
      adj[i] = a[mi3_pkg::PROD_A[2*i]] * a[mi3_pkg::PROD_B[2*i]]
             - a[mi3_pkg::PROD_A[2*i+1]] * a[mi3_pkg::PROD_B[2*i+1]];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int i = 0; i < mi3_pkg::NENT; i++) begin
      neg = (adj[i] < 0) != (det < 0);
      num = (adj[i] < 0) ? -adj[i] : adj[i];
      den = (det < 0) ? -det : det;
      num = ((num <<< (2 * F)) <<< 1) + den;
      q = num / (den <<< 1);
      lim = neg ? (wide_t'(1) <<< (W - 1)) : ((wide_t'(1) <<< (W - 1)) - 1);
      if (q > lim) begin
        q = lim;
        res.overflow = 1'b1;
      end
      if (neg) q = -q;
      res.r[i] = q[W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_matrix(entry_t m[mi3_pkg::NENT]);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    {req.m00, req.m01, req.m02, req.m10, req.m11, req.m12, req.m20, req.m21, req.m22}
      <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    do @(posedge clk); while (!req.ready);
    expected_q.push_back(invert_matrix(m));
    @(negedge clk);
  endtask

  always @(negedge clk)
    rsp.ready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    inverse_t want;
    entry_t got[mi3_pkg::NENT];
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.r00, rsp.r01, rsp.r02, rsp.r10, rsp.r11, rsp.r12, rsp.r20, rsp.r21, rsp.r22};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < mi3_pkg::NENT; i++)
          if (got[i] !== want.r[i]) report_mismatch($sformatf("r%0d", i), got[i], want.r[i]);
        if (rsp.singular !== want.singular)
          report_mismatch("singular", W'(rsp.singular), W'(want.singular));
        if (rsp.overflow !== want.overflow)
          report_mismatch("overflow", W'(rsp.overflow), W'(want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL matrix_inverse_3x3");
      $finish;
    end
  end

  function automatic entry_t rand_entry(int kind);
    case (kind)
      0: return entry_t'($urandom);
      1: return entry_t'($urandom_range(0, 8) <<< F) * ($urandom_range(1) ? 1 : -1);
      2: return entry_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return entry_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic test_directed();
    entry_t m[mi3_pkg::NENT];
    entry_t one = entry_t'(1 << F);
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};
    send_matrix(m);
    m = '{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2};
    send_matrix(m);
    m = '{default: 0};
    send_matrix(m);
    m = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{default: entry_t'(32'h7fffffff)};
    send_matrix(m);
    m = '{entry_t'(32'h80000000), 0, 0, 0, entry_t'(32'h7fffffff), 0, 0, 0, -1};
    send_matrix(m);
    m = '{entry_t'(32'h80000000), 1, 0, 0, entry_t'(32'h80000000), 1, 1, 0,
          entry_t'(32'h80000000)};
    send_matrix(m);
    m = '{3, 0, 0, 0, 3, 0, 0, 0, 3};
    send_matrix(m);
    m = '{0, one, 0, one, 0, 0, 0, 0, -one};
    send_matrix(m);
    m = '{one * 3, 0, 0, 0, one * 3, 0, 0, 0, one * 3};
    send_matrix(m);
    m = '{entry_t'(32'hffffffff), 0, 0, 0, entry_t'(32'hffffffff), 0, 0, 0,
          entry_t'(32'hffffffff)};
    send_matrix(m);
    m = '{entry_t'(32'h7fffffff), entry_t'(32'h80000000), 5, 7, entry_t'(32'h55555555),
          entry_t'(32'haaaaaaaa), 1, 2, 3};
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    entry_t m[mi3_pkg::NENT];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(3);
      for (int i = 0; i < mi3_pkg::NENT; i++) m[i] = rand_entry(kind);
      if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) m[6 + i] = m[i];
      send_matrix(m);
    end
  endtask

  task automatic test_drain_pause();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    req.valid = 1'b0;
    {req.m00, req.m01, req.m02, req.m10, req.m11, req.m12, req.m20, req.m21, req.m22} = '0;
    rsp.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(500);
    test_drain_pause();
    idle_pct = 0;
    test_random(300);
    idle_pct = 38;
    test_random(450);
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS matrix_inverse_3x3");
    end else begin
      $display("FAIL matrix_inverse_3x3");
    end
    $finish;
  end

endmodule
